FILE: rtl/core/mrpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpm_pkg: shared types and constants of the modbus rtu poll master
// crc-16 step, frame constants, register indices and the front/back command
// ----------------------------------------------------------------------------
package mrpm_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	localparam logic [7:0] FUNC_READ   = 8'd3;
	localparam logic [7:0] FUNC_WRITE  = 8'd6;
	localparam logic [7:0] READ_QTY    = 8'd1;
	localparam logic [7:0] WRITE_VALUE = 8'd5;

	localparam logic [7:0] MIN_FRAME = 8'd5;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic [7:0] MAX_SLAVE_RST    = 8'd10;
	localparam logic [7:0] HOLDING_BASE_RST = 8'd0;
	localparam logic [7:0] LED_OFFSET_RST   = 8'd0;
	localparam logic [7:0] FIRST_SLAVE      = 8'd1;

	localparam int CMD_DEPTH = 2;

	typedef enum logic [1:0] {
		REG_MAX_SLAVE    = 2'd0,
		REG_HOLDING_BASE = 2'd1,
		REG_LED_OFFSET   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		MODE_POLL = 1'b0,
		MODE_BYTE = 1'b1
	} mode_t;

	typedef enum logic {
		KIND_TX     = 1'b0,
		KIND_UPDATE = 1'b1
	} kind_t;

	// one unit of work for the back end: a request frame or a reply outcome
	typedef struct packed {
		logic        is_reply;
		logic [7:0]  addr;
		logic [7:0]  index;
		logic [15:0] value;
	} cmd_t;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/modbus_rtu_poll_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master_core: modbus rtu round-robin poll master
// front gathers reply bytes and issues commands, back emits frames and updates
//
// channel  direction  handshake           payload
// s_*      in         s_tvalid/s_tready   tdata rx_byte, tlast frame_end, tuser mode
// m_*      out        m_tvalid/m_tready   tdata tx_byte/index/value, tlast last, tuser kind
// cfg_*    in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// the front takes a received byte in any cycle that input ready is high; in the back end
// a poll tick is one load and eight bytes, an accepted reply a load, update, eight bytes
// the crc sequencer in the back end does one crc byte step a cycle unless stalled
// input ready drops only while the command queue (CMD_DEPTH entries) is full
// output stalls hold the output register; the front runs on meanwhile
// asynchronous active-low reset; no clearing pass is needed
// ----------------------------------------------------------------------------
module modbus_rtu_poll_master_core #(
	parameter int CMD_DEPTH = mrpm_pkg::CMD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] tx_byte, [15:8] update_index, [31:16] update_value
	output logic        m_tlast,
	output logic        m_tuser    // [0] kind
);

	mrpm_pkg::cmd_t push_cmd, pop_cmd;
	logic           q_ready, q_push, q_valid, q_pop;

	mrpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	mrpm_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (pop_cmd)
	);

	mrpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (pop_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: rtl/core/mrpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpm_front: input side of the poll master
// holds configuration, slave counter and reply gathering; checks each reply
// at frame end and pushes poll or reply commands into the queue
// ----------------------------------------------------------------------------
module mrpm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	input  logic                 s_tuser,
	input  logic                 q_ready,
	output logic                 q_push,
	output mrpm_pkg::cmd_t       q_cmd
);

	logic [7:0]  max_slave_q, holding_base_q, led_offset_q;
	logic [7:0]  next_slave_q, last_polled_q, rx_count_q;
	logic [7:0]  hdr_q [4];
	logic [7:0]  value_lo_q, tail_q;
	logic [15:0] crc0_q, crc1_q;

	logic        accept, is_poll, reply_ok;
	logic [7:0]  value_lo;

	assign cfg_ready = 1'b1;
	assign s_tready  = q_ready;
	assign accept    = s_tvalid && s_tready;
	assign is_poll   = (s_tuser == mrpm_pkg::MODE_POLL);

	// on a five-byte frame the value low byte is the one arriving now
	assign value_lo = (rx_count_q == 8'd4) ? s_tdata : value_lo_q;

	// crc over all but the last two bytes is the running crc two bytes back
	assign reply_ok = (rx_count_q >= (mrpm_pkg::MIN_FRAME - 8'd1))
		&& (hdr_q[0] == last_polled_q)
		&& (crc1_q[7:0] == tail_q)
		&& (crc1_q[15:8] == s_tdata)
		&& (hdr_q[1] == mrpm_pkg::FUNC_READ);

	always_comb begin
		q_cmd.is_reply = !is_poll;
		q_cmd.addr     = is_poll ? next_slave_q : 8'(led_offset_q + last_polled_q - 8'd1);
		q_cmd.index    = is_poll ? 8'd0 : 8'(holding_base_q + last_polled_q - 8'd1);
		q_cmd.value    = is_poll ? 16'd0 : {hdr_q[3], value_lo};
	end

	assign q_push = accept && (is_poll || (s_tlast && reply_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slave_q    <= mrpm_pkg::MAX_SLAVE_RST;
			holding_base_q <= mrpm_pkg::HOLDING_BASE_RST;
			led_offset_q   <= mrpm_pkg::LED_OFFSET_RST;
			next_slave_q   <= mrpm_pkg::FIRST_SLAVE;
			last_polled_q  <= 8'd0;
			rx_count_q     <= 8'd0;
			for (int i = 0; i < 4; i++) hdr_q[i] <= 8'd0;
			value_lo_q     <= 8'd0;
			tail_q         <= 8'd0;
			crc0_q         <= mrpm_pkg::CRC_INIT;
			crc1_q         <= mrpm_pkg::CRC_INIT;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mrpm_pkg::REG_MAX_SLAVE:    max_slave_q    <= cfg_data;
					mrpm_pkg::REG_HOLDING_BASE: holding_base_q <= cfg_data;
					mrpm_pkg::REG_LED_OFFSET:   led_offset_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept && is_poll) begin
				last_polled_q <= next_slave_q;
				if (next_slave_q >= max_slave_q) begin
					next_slave_q <= mrpm_pkg::FIRST_SLAVE;
				end else begin
					next_slave_q <= next_slave_q + 8'd1;
				end
			end else if (accept && s_tlast) begin
				// a frame end in byte mode drops the gathered frame
				rx_count_q <= 8'd0;
				for (int i = 0; i < 4; i++) hdr_q[i] <= 8'd0;
				value_lo_q <= 8'd0;
				tail_q     <= 8'd0;
				crc0_q     <= mrpm_pkg::CRC_INIT;
				crc1_q     <= mrpm_pkg::CRC_INIT;
			end else if (accept) begin
				if (rx_count_q < 8'd4) begin
					hdr_q[rx_count_q[1:0]] <= s_tdata;
				end
				if (rx_count_q == 8'd4) begin
					value_lo_q <= s_tdata;
				end
				crc1_q <= crc0_q;
				crc0_q <= mrpm_pkg::crc_add(crc0_q, s_tdata);
				tail_q <= s_tdata;
				if (rx_count_q != mrpm_pkg::COUNT_MAX) begin
					rx_count_q <= rx_count_q + 8'd1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/mrpm_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpm_cmd_fifo: short command queue between front and back
// register-based circular buffer with occupancy count
// ----------------------------------------------------------------------------
module mrpm_cmd_fifo #(
	parameter int DEPTH = mrpm_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrpm_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output mrpm_pkg::cmd_t pop_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mrpm_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign ready   = (count_q != CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !ready && !pop)) else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid)) else $error("command queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("command queue count out of range");

endmodule

FILE: rtl/core/mrpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpm_back: result sequencer of the poll master
// expands one command into an optional holding update and an 8-byte frame,
// with its crc built a byte per cycle unless stalled, into an output register
// ----------------------------------------------------------------------------
module mrpm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mrpm_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);

	mrpm_pkg::cmd_t cmd_q;
	logic           busy_q, out_valid_q;
	logic [3:0]     pos_q;
	logic [15:0]    crc_q;
	logic [31:0]    out_data_q;
	logic           out_last_q, out_kind_q;

	logic           advance, is_update, final_pos;
	logic [3:0]     fidx;
	logic [7:0]     fbyte;

	assign q_pop     = !busy_q && q_valid;
	assign advance   = busy_q && (!out_valid_q || m_tready);
	assign is_update = cmd_q.is_reply && (pos_q == 4'd0);
	assign fidx      = cmd_q.is_reply ? (pos_q - 4'd1) : pos_q;
	assign final_pos = (fidx == 4'd7) && !is_update;

	always_comb begin
		unique case (fidx)
			4'd0:    fbyte = cmd_q.addr;
			4'd1:    fbyte = cmd_q.is_reply ? mrpm_pkg::FUNC_WRITE : mrpm_pkg::FUNC_READ;
			4'd5:    fbyte = cmd_q.is_reply ? mrpm_pkg::WRITE_VALUE : mrpm_pkg::READ_QTY;
			4'd6:    fbyte = crc_q[7:0];
			4'd7:    fbyte = crc_q[15:8];
			default: fbyte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			crc_q <= mrpm_pkg::CRC_INIT;
		end else if (advance && !is_update && fidx < 4'd6) begin
			crc_q <= mrpm_pkg::crc_add(crc_q, fbyte);
		end
		if (advance) begin
			// tdata: tx_byte, update_index, update_value
			out_data_q <= is_update ? {cmd_q.value, cmd_q.index, 8'd0} : {24'd0, fbyte};
			out_kind_q <= is_update ? mrpm_pkg::KIND_UPDATE : mrpm_pkg::KIND_TX;
			out_last_q <= final_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= 4'd0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				pos_q  <= 4'd0;
			end else if (advance) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_q + 4'd1;
				if (final_pos) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

	// a reply command ends one past its last frame byte
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 4'd9) else $error("sequencer position out of range");

	a_update_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == mrpm_pkg::KIND_UPDATE) |-> !m_tlast)
		else $error("update result marked last");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (m_tvalid && m_tlast))
		else $error("command finished without a last result");

endmodule

FILE: sim/tb_modbus_rtu_poll_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_poll_master_core: self-checking bench for the poll master core
// sends poll ticks and reply bytes, predicts every request frame, holding
// update and led write frame, and checks each output transfer in order
// ----------------------------------------------------------------------------
module tb_modbus_rtu_poll_master_core;

	localparam int RUN_LIMIT  = 400000;
	localparam int SETTLE     = 30;
	localparam int HOLD_LEN   = 400;
	localparam int GAP_PCT    = 27;

	typedef struct {
		mrpm_pkg::kind_t kind;
		logic [7:0]      tx;
		logic [7:0]      idx;
		logic [15:0]     val;
		logic            fin;
	} master_out_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
	logic        s_tlast   = 1'b0;
	logic        s_tuser   = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [7:0] tx_byte, [15:8] update_index, [31:16] update_value
	logic        m_tlast;
	logic        m_tuser;          // [0] kind

	// predicted state of the core
	logic [7:0]  cur_max_slave = mrpm_pkg::MAX_SLAVE_RST;
	logic [7:0]  cur_hold_base = mrpm_pkg::HOLDING_BASE_RST;
	logic [7:0]  cur_led_off   = mrpm_pkg::LED_OFFSET_RST;
	logic [7:0]  nxt_slave     = mrpm_pkg::FIRST_SLAVE;
	logic [7:0]  polled_slave  = 8'd0;
	logic [7:0]  rx_cnt        = 8'd0;
	logic [7:0]  hdr [4];
	logic [7:0]  val_lo        = 8'd0;
	logic [15:0] crc_hist [3];
	logic [7:0]  tail [2];

	master_out_t due_outputs [$];
	logic [7:0]  frm [$];

	int err_cnt   = 0;
	int cycle_cnt = 0;
	int hold_left = 0;
	bit hold_req  = 1'b0;
	bit no_gaps   = 1'b0;

	modbus_rtu_poll_master_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// serial form of the reflected crc-16, one data bit per shift
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		int i;
		r = acc;
		for (i = 0; i < 8; i++) begin
			if (r[0] ^ d[i]) begin
				r = (r >> 1) ^ mrpm_pkg::CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic push_out(input mrpm_pkg::kind_t k, input logic [7:0] tx,
			input logic [7:0] idx, input logic [15:0] val, input logic fin);
		master_out_t r;
		r.kind = k;
		r.tx   = tx;
		r.idx  = idx;
		r.val  = val;
		r.fin  = fin;
		due_outputs.push_back(r);
	endtask

	task automatic queue_tx_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] word_lo, input logic fin);
		logic [7:0]  body [6];
		logic [15:0] c;
		int i;
		body[0] = addr;
		body[1] = func;
		body[2] = 8'd0;
		body[3] = 8'd0;
		body[4] = 8'd0;
		body[5] = word_lo;
		c = mrpm_pkg::CRC_INIT;
		for (i = 0; i < 6; i++) begin
			c = crc16_byte(c, body[i]);
			push_out(mrpm_pkg::KIND_TX, body[i], 8'd0, 16'd0, 1'b0);
		end
		push_out(mrpm_pkg::KIND_TX, c[7:0], 8'd0, 16'd0, 1'b0);
		push_out(mrpm_pkg::KIND_TX, c[15:8], 8'd0, 16'd0, fin);
	endtask

	task automatic clear_rx_state();
		int i;
		rx_cnt = 8'd0;
		val_lo = 8'd0;
		for (i = 0; i < 4; i++) hdr[i] = 8'd0;
		for (i = 0; i < 3; i++) crc_hist[i] = mrpm_pkg::CRC_INIT;
		tail[0] = 8'd0;
		tail[1] = 8'd0;
	endtask

	task automatic poll_tick_outputs();
		queue_tx_frame(nxt_slave, mrpm_pkg::FUNC_READ, mrpm_pkg::READ_QTY, 1'b1);
		polled_slave = nxt_slave;
		nxt_slave = (nxt_slave >= cur_max_slave) ? mrpm_pkg::FIRST_SLAVE : nxt_slave + 8'd1;
	endtask

	task automatic rx_byte_outputs(input logic [7:0] b, input logic fe);
		logic [7:0] prev;
		logic       ok;
		if (rx_cnt < 8'd4) begin
			hdr[rx_cnt[1:0]] = b;
		end else if (rx_cnt == 8'd4) begin
			val_lo = b;
		end
		crc_hist[2] = crc_hist[1];
		crc_hist[1] = crc_hist[0];
		crc_hist[0] = crc16_byte(crc_hist[0], b);
		prev = tail[1];
		tail[0] = tail[1];
		tail[1] = b;
		if (rx_cnt != mrpm_pkg::COUNT_MAX) rx_cnt = rx_cnt + 8'd1;
		if (fe) begin
			// crc two bytes back covers everything but the crc bytes themselves
			ok = rx_cnt >= mrpm_pkg::MIN_FRAME && hdr[0] == polled_slave &&
				crc_hist[2] == {b, prev} && hdr[1] == mrpm_pkg::FUNC_READ;
			if (ok) begin
				push_out(mrpm_pkg::KIND_UPDATE, 8'd0, cur_hold_base + polled_slave - 8'd1,
					{hdr[3], val_lo}, 1'b0);
				queue_tx_frame(cur_led_off + polled_slave - 8'd1, mrpm_pkg::FUNC_WRITE,
					mrpm_pkg::WRITE_VALUE, 1'b1);
			end
			clear_rx_state();
		end
	endtask

	task automatic check_result();
		master_out_t e;
		if (due_outputs.size() == 0) begin
			report_mismatch($sformatf("unexpected transfer tdata %h tuser %b tlast %b",
				m_tdata, m_tuser, m_tlast));
			return;
		end
		e = due_outputs.pop_front();
		if (m_tuser !== e.kind)
			report_mismatch($sformatf("kind %b, want %b", m_tuser, e.kind));
		if (m_tdata[7:0] !== e.tx)
			report_mismatch($sformatf("tx_byte %h, want %h", m_tdata[7:0], e.tx));
		if (m_tdata[15:8] !== e.idx)
			report_mismatch($sformatf("update_index %h, want %h", m_tdata[15:8], e.idx));
		if (m_tdata[31:16] !== e.val)
			report_mismatch($sformatf("update_value %h, want %h", m_tdata[31:16], e.val));
		if (m_tlast !== e.fin)
			report_mismatch($sformatf("last %b, want %b", m_tlast, e.fin));
	endtask

	// output side: random back-pressure, none without gaps, or a long hold when asked
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= GAP_PCT);
		end
	end

	task automatic send_item(input mrpm_pkg::mode_t md, input logic [7:0] b, input logic fe);
		if (!no_gaps && $urandom_range(99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 25);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fe;
		s_tuser  <= md;
		do @(posedge clk); while (!s_tready);
		if (md == mrpm_pkg::MODE_POLL) begin
			poll_tick_outputs();
		end else begin
			rx_byte_outputs(b, fe);
		end
	endtask

	task automatic send_rx_frame();
		int i;
		for (i = 0; i < frm.size(); i++) begin
			send_item(mrpm_pkg::MODE_BYTE, frm[i], i == frm.size() - 1);
		end
	endtask

	task automatic build_reply(input logic [7:0] addr, input logic [7:0] func,
			input logic [15:0] value);
		frm.delete();
		frm.push_back(addr);
		frm.push_back(func);
		frm.push_back(8'd2);
		frm.push_back(value[15:8]);
		frm.push_back(value[7:0]);
	endtask

	task automatic seal_frame();
		logic [15:0] c;
		int i;
		c = mrpm_pkg::CRC_INIT;
		for (i = 0; i < frm.size(); i++) c = crc16_byte(c, frm[i]);
		frm.push_back(c[7:0]);
		frm.push_back(c[15:8]);
	endtask

	// idle the input, let every predicted transfer arrive, then settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input mrpm_pkg::reg_idx_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mrpm_pkg::REG_MAX_SLAVE:    cur_max_slave = val;
			mrpm_pkg::REG_HOLDING_BASE: cur_hold_base = val;
			mrpm_pkg::REG_LED_OFFSET:   cur_led_off   = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] ms, input logic [7:0] hb, input logic [7:0] lo);
		wait_drained();
		write_reg(mrpm_pkg::REG_MAX_SLAVE, ms);
		write_reg(mrpm_pkg::REG_HOLDING_BASE, hb);
		write_reg(mrpm_pkg::REG_LED_OFFSET, lo);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		int i;
		// reply to address zero before any poll; five bytes, value low is crc high
		frm.delete();
		frm.push_back(8'h00);
		frm.push_back(mrpm_pkg::FUNC_READ);
		frm.push_back(8'h00);
		seal_frame();
		send_rx_frame();
		// poll with stray byte and frame end
		send_item(mrpm_pkg::MODE_POLL, 8'hFF, 1'b1);
		// four bytes with a good crc is still too short
		frm.delete();
		frm.push_back(polled_slave);
		frm.push_back(mrpm_pkg::FUNC_READ);
		seal_frame();
		send_rx_frame();
		// reply split by a poll tick, which must not end the frame
		build_reply(nxt_slave, mrpm_pkg::FUNC_READ, 16'hFFFF);
		seal_frame();
		for (i = 0; i < frm.size(); i++) begin
			if (i == 3) send_item(mrpm_pkg::MODE_POLL, 8'h00, 1'b1);
			send_item(mrpm_pkg::MODE_BYTE, frm[i], i == frm.size() - 1);
		end
		build_reply(polled_slave, mrpm_pkg::FUNC_READ, 16'h0000);
		seal_frame();
		send_rx_frame();
	endtask

	task automatic poll_round(input int n);
		repeat (n) begin
			send_item(mrpm_pkg::MODE_POLL, 8'($urandom), 1'($urandom_range(1)));
			build_reply(polled_slave, mrpm_pkg::FUNC_READ, 16'($urandom));
			seal_frame();
			send_rx_frame();
		end
	endtask

	task automatic test_config_sweep();
		configure(8'd1, 8'd0, 8'd0);
		poll_round(2);
		configure(8'd247, 8'd255, 8'd247);
		poll_round(2);
		// lowered below the next slave: that one is polled once, then wrap
		configure(8'd2, 8'd200, 8'd100);
		poll_round(3);
		configure(8'($urandom_range(1, 247)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 247)));
		poll_round(1);
		configure(8'd4, 8'd17, 8'd60);
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int pick;
		int k;
		int bsel;
		int len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_item(mrpm_pkg::MODE_POLL, 8'($urandom), 1'($urandom_range(1)));
				sent++;
			end else begin
				if (pick < 80) begin
					build_reply(polled_slave, mrpm_pkg::FUNC_READ, 16'($urandom));
					if ($urandom_range(9) == 0) begin
						repeat ($urandom_range(1, 6)) frm.push_back(8'($urandom));
					end
					seal_frame();
					if (pick >= 60) begin
						// single bit error anywhere in the frame
						k = $urandom_range(frm.size() - 1);
						bsel = $urandom_range(7);
						frm[k][bsel] = ~frm[k][bsel];
					end
				end else if (pick < 86) begin
					build_reply(polled_slave, 8'($urandom), 16'($urandom));
					seal_frame();
				end else if (pick < 91) begin
					build_reply(polled_slave + 8'($urandom_range(1, 255)), mrpm_pkg::FUNC_READ,
						16'($urandom));
					seal_frame();
				end else begin
					// noise, short runs among it
					frm.delete();
					len = (pick < 95) ? $urandom_range(1, 4) : $urandom_range(1, 12);
					repeat (len) frm.push_back(8'($urandom));
				end
				send_rx_frame();
				sent += frm.size();
			end
		end
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		test_random_traffic(30);
		no_gaps = 1'b0;
	endtask

	task automatic test_output_hold();
		wait_drained();
		hold_req = 1'b1;
		// queue fills during the hold and input ready drops
		repeat (12) send_item(mrpm_pkg::MODE_POLL, 8'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic test_long_frame();
		send_item(mrpm_pkg::MODE_POLL, 8'h00, 1'b0);
		build_reply(polled_slave, mrpm_pkg::FUNC_READ, 16'($urandom));
		// past the saturation point of the byte count
		while (frm.size() < 254) frm.push_back(8'($urandom));
		seal_frame();
		send_rx_frame();
	endtask

	initial begin
		clear_rx_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_traffic(30);
		test_back_to_back();
		test_output_hold();
		test_long_frame();
		wait_drained();
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/mrpm_pkg.sv
rtl/core/mrpm_front.sv
rtl/core/mrpm_cmd_fifo.sv
rtl/core/mrpm_back.sv
rtl/core/modbus_rtu_poll_master_core.sv
sim/tb_modbus_rtu_poll_master_core.sv
